// ===== design/bafp_pkg.sv =====
package bafp_pkg;

    // point and angle formats
    localparam int COORD_WIDTH  = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;
    localparam int NUM_STEPS    = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam int SCALE_SHIFT  = 24;
    localparam int ANG_FRAC     = 20;
    localparam int DIFF_W       = COORD_WIDTH + 1;
    // headroom for cordic gain and the first add
    localparam int XY_W         = DIFF_W + SCALE_SHIFT + 3;
    // accumulator spans about -100 .. 280 degrees
    localparam int ANG_W        = 30;
    localparam int WRAP_W       = ANG_W - 1;
    localparam int OUT_W        = 17;
    localparam int RND_SHIFT    = ANG_FRAC - 8;
    localparam int Q_W          = ANG_W - RND_SHIFT;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]      diff_t;
    typedef logic signed [XY_W-1:0]        xy_t;
    typedef logic signed [ANG_W-1:0]       zang_t;
    typedef logic        [OUT_W-1:0]       bear_t;

    localparam zang_t DEG180 = ANG_W'(180 * (2 ** ANG_FRAC));
    localparam zang_t DEG360 = ANG_W'(360 * (2 ** ANG_FRAC));

    localparam bear_t BEAR_0    = OUT_W'(0);
    localparam bear_t BEAR_90   = OUT_W'(90 * 256);
    localparam bear_t BEAR_180  = OUT_W'(180 * 256);
    localparam bear_t BEAR_270  = OUT_W'(270 * 256);
    localparam int    FULL_TURN = 360 * 256;

    // atan(2^-i) in degrees, 20 fraction bits
    localparam zang_t ATAN_TAB [TABLE_LEN] = '{
        ANG_W'(47185920), ANG_W'(27855475), ANG_W'(14718068), ANG_W'(7471121),
        ANG_W'(3750058),  ANG_W'(1876857),  ANG_W'(938658),   ANG_W'(469357),
        ANG_W'(234682),   ANG_W'(117342),   ANG_W'(58671),    ANG_W'(29335),
        ANG_W'(14668),    ANG_W'(7334),     ANG_W'(3667),     ANG_W'(1833),
        ANG_W'(917),      ANG_W'(458),      ANG_W'(229),      ANG_W'(115),
        ANG_W'(57),       ANG_W'(29),       ANG_W'(14),       ANG_W'(7)
    };

    // angle plus the result of the axis cases
    typedef struct packed {
        zang_t z;
        logic  special;
        bear_t spec_val;
    } tag_t;

    typedef struct packed {
        xy_t  x;
        xy_t  y;
        tag_t tag;
    } rot_t;

endpackage

// ===== design/bafp_prep.sv =====
module bafp_prep (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  bafp_pkg::coord_t first_x,
    input  bafp_pkg::coord_t first_y,
    input  bafp_pkg::coord_t second_x,
    input  bafp_pkg::coord_t second_y,
    output logic             out_valid,
    input  logic             out_ready,
    output bafp_pkg::rot_t   out_data
);
    import bafp_pkg::*;

    logic  d_valid_reg;
    diff_t dx_reg, dz_reg, dx_next, dz_next;
    logic  r_valid_reg;
    rot_t  rot_reg, rot_next;
    logic  d_ready, r_ready;

    xy_t   dxw, dzw, xa, ya;
    logic  dz_neg;

    assign r_ready  = !r_valid_reg || out_ready;
    assign d_ready  = !d_valid_reg || r_ready;
    assign in_ready = d_ready;

    // differences, exact in one extra bit
    always_comb begin
        dx_next = diff_t'(first_x) - diff_t'(second_x);
        dz_next = diff_t'(first_y) - diff_t'(second_y);
    end

    // axis cases and turn into the right half plane
    always_comb begin
        dz_neg = dz_reg[DIFF_W-1];
        dxw    = xy_t'(dx_reg);
        dzw    = xy_t'(dz_reg);
        xa     = dz_neg ? -dzw : dzw;
        ya     = dz_neg ? -dxw : dxw;
        rot_next.x            = xa <<< SCALE_SHIFT;
        rot_next.y            = ya <<< SCALE_SHIFT;
        rot_next.tag.z        = dz_neg ? DEG180 : '0;
        rot_next.tag.special  = 1'b0;
        rot_next.tag.spec_val = BEAR_0;
        if (dx_reg == '0) begin
            rot_next.tag.special  = 1'b1;
            rot_next.tag.spec_val = (!dz_neg && dz_reg != '0) ? BEAR_0 : BEAR_180;
        end else if (dz_reg == '0) begin
            rot_next.tag.special  = 1'b1;
            rot_next.tag.spec_val = dx_reg[DIFF_W-1] ? BEAR_270 : BEAR_90;
        end
        if (rot_next.tag.special) begin
            rot_next.x     = '0;
            rot_next.y     = '0;
            rot_next.tag.z = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
        end else begin
            if (d_ready) begin
                d_valid_reg <= in_valid;
            end
            if (r_ready) begin
                r_valid_reg <= d_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (d_ready && in_valid) begin
            dx_reg <= dx_next;
            dz_reg <= dz_next;
        end
        if (r_ready && d_valid_reg) begin
            rot_reg <= rot_next;
        end
    end

    assign out_valid = r_valid_reg;
    assign out_data  = rot_reg;

endmodule

// ===== design/bafp_cordic.sv =====
module bafp_cordic (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  bafp_pkg::rot_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output bafp_pkg::tag_t out_data
);
    import bafp_pkg::*;

    rot_t                 st_reg [NUM_STEPS];
    logic [NUM_STEPS-1:0] vld_reg;
    rot_t                 src    [NUM_STEPS];
    logic [NUM_STEPS-1:0] src_vld;
    logic [NUM_STEPS:0]   rdy;

    assign rdy[NUM_STEPS] = out_ready;
    assign src[0]         = in_data;
    assign src_vld[0]     = in_valid;

    for (genvar k = 0; k < NUM_STEPS; k++) begin : g_step
        rot_t st_next;
        xy_t  xi, yi, xs, ys;

        if (k > 0) begin : g_link
            assign src[k]     = st_reg[k-1];
            assign src_vld[k] = vld_reg[k-1];
        end

        assign rdy[k] = !vld_reg[k] || rdy[k+1];

        // one vectoring rotation, drive y toward zero
        always_comb begin
            xi      = src[k].x;
            yi      = src[k].y;
            xs      = xi >>> k;
            ys      = yi >>> k;
            st_next = src[k];
            if (!yi[XY_W-1]) begin
                st_next.x     = xi + ys;
                st_next.y     = yi - xs;
                st_next.tag.z = src[k].tag.z + ATAN_TAB[k];
            end else begin
                st_next.x     = xi - ys;
                st_next.y     = yi + xs;
                st_next.tag.z = src[k].tag.z - ATAN_TAB[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                vld_reg[k] <= src_vld[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[k] && src_vld[k]) begin
                st_reg[k] <= st_next;
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[NUM_STEPS-1];
    assign out_data  = st_reg[NUM_STEPS-1].tag;

    // x starts positive and only grows in vectoring mode
    a_x_positive: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[NUM_STEPS-1] && !st_reg[NUM_STEPS-1].tag.special)
            |-> (!st_reg[NUM_STEPS-1].x[XY_W-1] && st_reg[NUM_STEPS-1].x != '0))
        else $error("cordic x left the right half plane");

endmodule

// ===== design/bafp_post.sv =====
module bafp_post (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  bafp_pkg::tag_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output bafp_pkg::bear_t out_data
);
    import bafp_pkg::*;

    localparam logic [ANG_W-1:0] RND_HALF = ANG_W'(2 ** (RND_SHIFT - 1));
    localparam logic [Q_W-1:0]   Q_FULL   = Q_W'(FULL_TURN);

    logic              w_valid_reg;
    logic [WRAP_W-1:0] zw_reg, zw_next;
    logic              sp_reg;
    bear_t             sv_reg;
    logic              o_valid_reg;
    bear_t             bear_reg, bear_next;
    logic              w_ready, o_ready;

    logic [ANG_W-1:0]  rnd;
    logic [Q_W-1:0]    q;

    assign o_ready  = !o_valid_reg || out_ready;
    assign w_ready  = !w_valid_reg || o_ready;
    assign in_ready = w_ready;

    // wrap into [0,360)
    always_comb begin
        if (in_data.z[ANG_W-1]) begin
            zw_next = WRAP_W'(in_data.z + DEG360);
        end else begin
            zw_next = WRAP_W'(in_data.z);
        end
    end

    // round half up to 1/256 degree, fold 360 back to 0
    always_comb begin
        rnd = {1'b0, zw_reg} + RND_HALF;
        q   = rnd[ANG_W-1:RND_SHIFT];
        if (sp_reg) begin
            bear_next = sv_reg;
        end else if (q >= Q_FULL) begin
            bear_next = OUT_W'(q - Q_FULL);
        end else begin
            bear_next = OUT_W'(q);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            if (w_ready) begin
                w_valid_reg <= in_valid;
            end
            if (o_ready) begin
                o_valid_reg <= w_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (w_ready && in_valid) begin
            zw_reg <= zw_next;
            sp_reg <= in_data.special;
            sv_reg <= in_data.spec_val;
        end
        if (o_ready && w_valid_reg) begin
            bear_reg <= bear_next;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_data  = bear_reg;

    a_wrapped: assert property (@(posedge aclk) disable iff (!aresetn)
        (w_valid_reg && !sp_reg) |-> ({1'b0, zw_reg} < DEG360))
        else $error("wrapped angle not below a full turn");

endmodule

// ===== design/bearing_angle_from_points.sv =====
// channel  dir  ports                                                      transaction
// s_       in   s_valid s_ready s_first_x s_first_y s_second_x s_second_y  one pair of points
// m_       out  m_valid m_ready m_bearing_deg                              one bearing, Q9.8 deg
//
// pipeline: 2 prep stages, 16 cordic stages, 2 wrap/round stages
// one transaction per cycle unless m_ stalls; every stage is a register with its own valid
// reset (aresetn low, synchronous) clears only the valid bits
// a stall on m_ holds the output register; bubbles upstream still fill,
// so s_ready drops only once every stage holds an item
module bearing_angle_from_points (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  bafp_pkg::coord_t s_first_x,
    input  bafp_pkg::coord_t s_first_y,
    input  bafp_pkg::coord_t s_second_x,
    input  bafp_pkg::coord_t s_second_y,
    output logic             m_valid,
    input  logic             m_ready,
    output bafp_pkg::bear_t  m_bearing_deg
);
    import bafp_pkg::*;

    // prep -> cordic
    logic pc_valid, pc_ready;
    rot_t pc_data;

    // cordic -> post
    logic cp_valid, cp_ready;
    tag_t cp_data;

    // differences, axis cases, half-plane turn and scaling
    bafp_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .first_x   (s_first_x),
        .first_y   (s_first_y),
        .second_x  (s_second_x),
        .second_y  (s_second_y),
        .out_valid (pc_valid),
        .out_ready (pc_ready),
        .out_data  (pc_data)
    );

    // one vectoring iteration per stage
    bafp_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (pc_valid),
        .in_ready  (pc_ready),
        .in_data   (pc_data),
        .out_valid (cp_valid),
        .out_ready (cp_ready),
        .out_data  (cp_data)
    );

    // wrap to a full turn, round to 1/256 degree, output register
    bafp_post u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cp_valid),
        .in_ready  (cp_ready),
        .in_data   (cp_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_bearing_deg)
    );

    // result always inside [0,360)
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_bearing_deg) < FULL_TURN))
        else $error("bearing out of range");

    // input back-pressure only comes from a stalled output
    a_no_false_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled while output drains");

endmodule
